@@ rtl/core/pdps_pkg.sv @@
// ----------------------------------------------------------------------------
// pdps_pkg
// Shared widths, codes, constants and tdata bit positions for the periodic
// dose pump scheduler.
// ----------------------------------------------------------------------------
package pdps_pkg;

  // Scheduler clock width (16..64)
  localparam int TIME_W     = 32;
  // Shared subtract/compare unit width
  localparam int UNIT_W     = (TIME_W > 32) ? TIME_W : 32;

  localparam int FLOW_W     = 17;
  localparam int VOL_W      = 16;
  localparam int MS_W       = 16;
  localparam int IVL_W      = 32;
  localparam int SUM_W      = 32;
  localparam int KIND_W     = 2;
  localparam int CHAN_W     = 8;
  localparam int STAT_W     = 3;

  // 6000 * 65535 fits in 29 bits
  localparam int DOSE_SCALE = 6000;
  localparam int PROD_W     = 29;
  localparam int CNT_W      = $clog2(PROD_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_USER_W  = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 112;

  localparam logic [MS_W-1:0]   MAX_DOSE_RST = 16'hFFFF;
  localparam logic [KIND_W-1:0] KIND_DIGITAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DC      = 2'd1;
  localparam logic [CHAN_W-1:0] DIG_CH_LO    = 8'd21;
  localparam logic [CHAN_W-1:0] DIG_CH_HI    = 8'd25;
  localparam logic [CHAN_W-1:0] DC_CH_LO     = 8'd27;
  localparam logic [CHAN_W-1:0] DC_CH_HI     = 8'd30;

  // Result tdata bit positions
  localparam int O_PUMP     = 0;
  localparam int O_FAULT    = 1;
  localparam int O_BEGAN    = 2;
  localparam int O_ENDED    = 3;
  localparam int O_FAILED   = 4;
  localparam int O_REFUSED  = 5;
  localparam int O_STAT_LO  = 6;
  localparam int O_TOTAL_LO = O_STAT_LO + STAT_W;
  localparam int O_IVL_LO   = O_TOTAL_LO + SUM_W;
  localparam int O_DOSE_LO  = O_IVL_LO + IVL_W;
  localparam int O_FLOW_LO  = O_DOSE_LO + MS_W;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_MANUAL,
    OP_CLEAR,
    OP_APPLY
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_CAPPED,
    ST_LIMITED,
    ST_BAD_VOLUME,
    ST_DISABLED,
    ST_NO_APPLY
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_ENABLE,
    CFG_FLOW_SETPOINT,
    CFG_DOSE_VOLUME,
    CFG_DOSE_TIME,
    CFG_MIN_INTERVAL,
    CFG_MAX_DOSE,
    CFG_DRIVE_KIND,
    CFG_DRIVE_CHANNEL
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TADV,
    S_ESUB,
    S_ECMP,
    S_ISUB,
    S_ICMP,
    S_START,
    S_CLEAR,
    S_APPLY,
    S_DIV,
    S_CAP,
    S_CLMIN,
    S_CLMAX,
    S_FIN
  } state_t;

endpackage

@@ rtl/core/periodic_dose_pump_scheduler.sv @@
// Steps: a tick advances time, ends an expired dose, then may start one; a
//   manual dose may start one; clear volume, or apply with a bad volume or
//   zero flow, goes to the result; else apply divides, twice when capped, each
//   quotient in 29 steps of the bit-serial divider on the shared unit.
// Throughput: one transaction at a time; input is ready as the result appears.
// Reset (rst_n low, synchronous): state, flags and settings clear, max dose
//   reads 65535, no result pending; working registers and tdata are not reset.
// ----------------------------------------------------------------------------
// periodic_dose_pump_scheduler
// Sequencer around one shared subtract/compare unit that runs ticks, manual
// doses, volume clears and settings application with a restoring divider.
// ----------------------------------------------------------------------------
module periodic_dose_pump_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  // tuser: opcode[1:0]
  input  logic [pdps_pkg::IN_USER_W-1:0]    in_tuser,
  // tdata: drive_ready[0], zero fill [7:1]
  input  logic [pdps_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: pump_on, fault_flag, dose_began, dose_ended, start_failed,
  //   manual_refused, settings_status[2:0], total_volume_ul[31:0],
  //   interval_now_ms[31:0], dose_now_ms[15:0], flow_now[16:0], zero fill
  output logic [pdps_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pdps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pdps_pkg::*;

  // configuration
  logic              auto_en_r;
  logic [FLOW_W-1:0] flow_set_r;
  logic [VOL_W-1:0]  vol_r;
  logic [MS_W-1:0]   dose_time_r;
  logic [IVL_W-1:0]  min_ivl_r;
  logic [MS_W-1:0]   max_dose_r;
  logic [KIND_W-1:0] kind_r;
  logic [CHAN_W-1:0] chan_r;

  // scheduler state
  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TIME_W-1:0] last_start_r, last_start_nxt;
  logic [TIME_W-1:0] dose_start_r, dose_start_nxt;
  logic              dosing_r, dosing_nxt;
  logic [SUM_W-1:0]  vol_sum_r, vol_sum_nxt;
  logic              fault_r, fault_nxt;
  logic [IVL_W-1:0]  interval_r, interval_nxt;
  logic [MS_W-1:0]   on_time_r, on_time_nxt;
  logic [FLOW_W-1:0] flow_r, flow_nxt;

  // per-transaction flags
  logic              began_r, began_nxt;
  logic              ended_r, ended_nxt;
  logic              failed_r, failed_nxt;
  logic              refused_r, refused_nxt;
  status_t           status_r, status_nxt;
  logic              second_r, second_nxt;
  logic              lim_r, lim_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;

  // working registers
  opcode_t                 op_r, op_nxt;
  logic                    ready_r, ready_nxt;
  logic [TIME_W-1:0]       diff_r, diff_nxt;
  logic [PROD_W-1:0]       quo_r, quo_nxt;
  logic [FLOW_W-1:0]       rem_r, rem_nxt;
  logic [FLOW_W-1:0]       div_r, div_nxt;
  logic [IVL_W-1:0]        iv_r, iv_nxt;
  logic [OUT_DATA_W-1:0]   out_tdata_r, out_tdata_nxt;

  // shared unit
  logic [UNIT_W-1:0] unit_a, unit_b;
  logic [UNIT_W:0]   unit_dif;
  logic              unit_ge;
  logic [FLOW_W:0]   trial;
  logic [PROD_W-1:0] product;
  logic              chan_ok;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;
  assign cfg_ready  = 1'b1;

  assign trial   = {rem_r, quo_r[PROD_W-1]};
  assign product = PROD_W'(vol_r) * PROD_W'(DOSE_SCALE);
  assign chan_ok = ((kind_r == KIND_DIGITAL) && (chan_r >= DIG_CH_LO) && (chan_r <= DIG_CH_HI))
                || ((kind_r == KIND_DC) && (chan_r >= DC_CH_LO) && (chan_r <= DC_CH_HI));

  // operand select for the shared subtract/compare unit
  always_comb begin
    unit_a = '0;
    unit_b = '0;
    case (state_r)
      S_ESUB: begin
        unit_a = UNIT_W'(time_r);
        unit_b = UNIT_W'(dose_start_r);
      end
      S_ECMP: begin
        unit_a = UNIT_W'(diff_r);
        unit_b = UNIT_W'(on_time_r);
      end
      S_ISUB: begin
        unit_a = UNIT_W'(time_r);
        unit_b = UNIT_W'(last_start_r);
      end
      S_ICMP: begin
        unit_a = UNIT_W'(diff_r);
        unit_b = UNIT_W'(interval_r);
      end
      S_DIV: begin
        unit_a = UNIT_W'(trial);
        unit_b = UNIT_W'(div_r);
      end
      S_CAP: begin
        unit_a = UNIT_W'(iv_r);
        unit_b = UNIT_W'(dose_time_r);
      end
      S_CLMIN: begin
        unit_a = UNIT_W'(iv_r);
        unit_b = UNIT_W'(min_ivl_r);
      end
      S_CLMAX: begin
        unit_a = UNIT_W'(max_dose_r);
        unit_b = UNIT_W'(on_time_r);
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  assign unit_dif = {1'b0, unit_a} - {1'b0, unit_b};
  assign unit_ge  = ~unit_dif[UNIT_W];

  always_comb begin
    logic [PROD_W-1:0] q_step;
    logic              lim_v;
    logic [SUM_W:0]    sum_w;

    q_step = {quo_r[PROD_W-2:0], unit_ge};
    lim_v  = lim_r | ~unit_ge;
    sum_w  = {1'b0, vol_sum_r} + (SUM_W+1)'(vol_r);

    state_nxt      = state_r;
    time_nxt       = time_r;
    last_start_nxt = last_start_r;
    dose_start_nxt = dose_start_r;
    dosing_nxt     = dosing_r;
    vol_sum_nxt    = vol_sum_r;
    fault_nxt      = fault_r;
    interval_nxt   = interval_r;
    on_time_nxt    = on_time_r;
    flow_nxt       = flow_r;
    began_nxt      = began_r;
    ended_nxt      = ended_r;
    failed_nxt     = failed_r;
    refused_nxt    = refused_r;
    status_nxt     = status_r;
    second_nxt     = second_r;
    lim_nxt        = lim_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    ready_nxt      = ready_r;
    diff_nxt       = diff_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    iv_nxt         = iv_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt      = opcode_t'(in_tuser);
          ready_nxt   = in_tdata[0];
          began_nxt   = 1'b0;
          ended_nxt   = 1'b0;
          failed_nxt  = 1'b0;
          refused_nxt = 1'b0;
          status_nxt  = ST_NO_APPLY;
          case (opcode_t'(in_tuser))
            OP_TICK:   state_nxt = S_TADV;
            OP_MANUAL: state_nxt = S_ISUB;
            OP_CLEAR:  state_nxt = S_CLEAR;
            OP_APPLY:  state_nxt = S_APPLY;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_TADV: begin
        time_nxt  = time_r + TIME_W'(1);
        state_nxt = S_ESUB;
      end
      S_ESUB: begin
        diff_nxt  = unit_dif[TIME_W-1:0];
        state_nxt = S_ECMP;
      end
      S_ECMP: begin
        // end an expired dose
        if (dosing_r && unit_ge) begin
          dosing_nxt = 1'b0;
          ended_nxt  = 1'b1;
        end
        state_nxt = S_ISUB;
      end
      S_ISUB: begin
        diff_nxt = unit_dif[TIME_W-1:0];
        if (op_r == OP_TICK) begin
          if (auto_en_r && !dosing_r && (interval_r != '0)) begin
            state_nxt = S_ICMP;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (dosing_r || (interval_r == '0)) begin
          refused_nxt = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          state_nxt = S_ICMP;
        end
      end
      S_ICMP: begin
        if (unit_ge) begin
          state_nxt = S_START;
        end else begin
          refused_nxt = (op_r == OP_MANUAL);
          state_nxt   = S_FIN;
        end
      end
      S_START: begin
        if (!chan_ok || !ready_r) begin
          fault_nxt  = 1'b1;
          failed_nxt = 1'b1;
        end else begin
          dosing_nxt     = 1'b1;
          began_nxt      = 1'b1;
          dose_start_nxt = time_r;
          last_start_nxt = time_r;
          // saturate the volume sum
          vol_sum_nxt    = sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];
        end
        state_nxt = S_FIN;
      end
      S_CLEAR: begin
        vol_sum_nxt = '0;
        state_nxt   = S_FIN;
      end
      S_APPLY: begin
        flow_nxt = flow_set_r;
        if (vol_r == '0) begin
          fault_nxt    = 1'b1;
          interval_nxt = '0;
          status_nxt   = ST_BAD_VOLUME;
          state_nxt    = S_FIN;
        end else if (flow_set_r == '0) begin
          fault_nxt    = 1'b0;
          interval_nxt = '0;
          status_nxt   = ST_DISABLED;
          state_nxt    = S_FIN;
        end else begin
          quo_nxt    = product;
          rem_nxt    = '0;
          div_nxt    = flow_set_r;
          cnt_nxt    = '0;
          second_nxt = 1'b0;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        // one restoring step per cycle, quotient shifts in at the bottom
        rem_nxt = unit_ge ? unit_dif[FLOW_W-1:0] : trial[FLOW_W-1:0];
        quo_nxt = q_step;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          if (second_r) begin
            flow_nxt   = q_step[FLOW_W-1:0];
            fault_nxt  = 1'b1;
            status_nxt = ST_CAPPED;
            state_nxt  = S_FIN;
          end else begin
            iv_nxt    = IVL_W'(q_step);
            state_nxt = S_CAP;
          end
        end
      end
      S_CAP: begin
        on_time_nxt = dose_time_r;
        if (!unit_ge) begin
          // interval shorter than the dose: cap it and derive a lower flow
          interval_nxt = IVL_W'(dose_time_r);
          quo_nxt      = product;
          rem_nxt      = '0;
          div_nxt      = FLOW_W'(dose_time_r);
          cnt_nxt      = '0;
          second_nxt   = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          lim_nxt   = 1'b0;
          state_nxt = S_CLMIN;
        end
      end
      S_CLMIN: begin
        if (!unit_ge) begin
          iv_nxt  = min_ivl_r;
          lim_nxt = 1'b1;
        end
        state_nxt = S_CLMAX;
      end
      S_CLMAX: begin
        if (!unit_ge) begin
          on_time_nxt = max_dose_r;
        end
        lim_nxt      = lim_v;
        interval_nxt = iv_r;
        fault_nxt    = lim_v;
        status_nxt   = lim_v ? ST_LIMITED : ST_OK;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        // hold until the output slot is free
        if (!out_tvalid_r || out_tready) begin
          out_tdata_nxt                          = '0;
          out_tdata_nxt[O_PUMP]                  = dosing_r;
          out_tdata_nxt[O_FAULT]                 = fault_r;
          out_tdata_nxt[O_BEGAN]                 = began_r;
          out_tdata_nxt[O_ENDED]                 = ended_r;
          out_tdata_nxt[O_FAILED]                = failed_r;
          out_tdata_nxt[O_REFUSED]               = refused_r;
          out_tdata_nxt[O_STAT_LO +: STAT_W]     = STAT_W'(status_r);
          out_tdata_nxt[O_TOTAL_LO +: SUM_W]     = vol_sum_r;
          out_tdata_nxt[O_IVL_LO +: IVL_W]       = interval_r;
          out_tdata_nxt[O_DOSE_LO +: MS_W]       = on_time_r;
          out_tdata_nxt[O_FLOW_LO +: FLOW_W]     = flow_r;
          out_tvalid_nxt                         = 1'b1;
          state_nxt                              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      time_r       <= '0;
      last_start_r <= '0;
      dose_start_r <= '0;
      dosing_r     <= 1'b0;
      vol_sum_r    <= '0;
      fault_r      <= 1'b0;
      interval_r   <= '0;
      on_time_r    <= '0;
      flow_r       <= '0;
      began_r      <= 1'b0;
      ended_r      <= 1'b0;
      failed_r     <= 1'b0;
      refused_r    <= 1'b0;
      status_r     <= ST_NO_APPLY;
      second_r     <= 1'b0;
      lim_r        <= 1'b0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      time_r       <= time_nxt;
      last_start_r <= last_start_nxt;
      dose_start_r <= dose_start_nxt;
      dosing_r     <= dosing_nxt;
      vol_sum_r    <= vol_sum_nxt;
      fault_r      <= fault_nxt;
      interval_r   <= interval_nxt;
      on_time_r    <= on_time_nxt;
      flow_r       <= flow_nxt;
      began_r      <= began_nxt;
      ended_r      <= ended_nxt;
      failed_r     <= failed_nxt;
      refused_r    <= refused_nxt;
      status_r     <= status_nxt;
      second_r     <= second_nxt;
      lim_r        <= lim_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    ready_r     <= ready_nxt;
    diff_r      <= diff_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    iv_r        <= iv_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_en_r   <= 1'b0;
      flow_set_r  <= '0;
      vol_r       <= '0;
      dose_time_r <= '0;
      min_ivl_r   <= '0;
      max_dose_r  <= MAX_DOSE_RST;
      kind_r      <= '0;
      chan_r      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_AUTO_ENABLE:   auto_en_r   <= cfg_data[0];
        CFG_FLOW_SETPOINT: flow_set_r  <= cfg_data[FLOW_W-1:0];
        CFG_DOSE_VOLUME:   vol_r       <= cfg_data[VOL_W-1:0];
        CFG_DOSE_TIME:     dose_time_r <= cfg_data[MS_W-1:0];
        CFG_MIN_INTERVAL:  min_ivl_r   <= cfg_data[IVL_W-1:0];
        CFG_MAX_DOSE:      max_dose_r  <= cfg_data[MS_W-1:0];
        CFG_DRIVE_KIND:    kind_r      <= cfg_data[KIND_W-1:0];
        CFG_DRIVE_CHANNEL: chan_r      <= cfg_data[CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/core/pdps_checker.sv @@
// ----------------------------------------------------------------------------
// pdps_checker
// Port-level checks on the dose pump scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pdps_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [pdps_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready
);
  import pdps_pkg::*;

  // a stalled result transaction holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

  // one transaction in flight: busy right after accepting
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in progress");

  // settings status only uses defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[O_STAT_LO +: STAT_W] <= STAT_W'(ST_NO_APPLY)))
    else $error("undefined settings status");

  // a started dose leaves the pump on and excludes failure or refusal
  a_began_on: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[O_BEGAN]) |->
      (out_tdata[O_PUMP] && !out_tdata[O_FAILED] && !out_tdata[O_REFUSED]))
    else $error("dose start inconsistent with pump state");

  // a failed start always latches the fault
  a_fail_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[O_FAILED]) |-> out_tdata[O_FAULT])
    else $error("failed start without fault");

endmodule

bind periodic_dose_pump_scheduler pdps_checker u_pdps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
